// ----- design/ivw_pkg.sv -----
// ----------------------------------------------------------------------------
// ivw_pkg: shared types and constants for the interval walk block
// Item and result structs, opcode and status codes, table entry layout,
// sequencer states and shared adder operations.
// ----------------------------------------------------------------------------
package ivw_pkg;

    // Width of every value, bound and rank
    localparam int VALUE_BITS = 60;
    localparam int SUM_W      = VALUE_BITS + 1;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [SUM_W-1:0]      sum_t;

    localparam value_t VALUE_MAX = '1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_RANK_ZERO = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    typedef struct packed {
        op_t    op;
        value_t interval_low;
        value_t interval_high;
        value_t rank;
    } in_item_t;

    typedef struct packed {
        value_t  value;
        status_t status;
    } out_item_t;

    // One row of the interval table
    typedef struct packed {
        value_t start_value;
        value_t length;
        value_t end_value;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APP_DIFF,
        S_APP_LEN,
        S_Q_INIT,
        S_Q_WALK,
        S_Q_FIN,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        ALU_DEC,
        ALU_SUB,
        ALU_INC,
        ALU_ADD,
        ALU_ADD_INC
    } alu_op_t;

endpackage

// ----- design/rank_to_value_interval_walk_top.sv -----
// ----------------------------------------------------------------------------
// rank_to_value_interval_walk_top: k-th value in a table of sorted intervals
// Clears the table, appends intervals, and maps a one-based rank to its value
// by walking the stored intervals.
// ----------------------------------------------------------------------------
// Takes one item at a time and gives one result per item. A clear, a dropped
// append or a query answered with an error goes straight to its result, an
// append first forms the row length, and a query walks at most the entry
// count of rows (MAX_INTERVALS, by default 256) before its result. The walk
// reads one table row per cycle from the table memory, which has one write
// port and one read port, and runs it through the one shared adder, which
// also forms rank - 1, interval lengths and the final sum. The table needs no
// clearing after reset. The output register holds a result while the next
// item is already taken.
module rank_to_value_interval_walk_top #(
    parameter int MAX_INTERVALS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  ivw_pkg::in_item_t  cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ivw_pkg::out_item_t rsp
);
    import ivw_pkg::*;

    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

    logic             rsp_free;
    logic             res_load;
    out_item_t        res;
    alu_op_t          alu_op;
    value_t           alu_a;
    value_t           alu_b;
    sum_t             alu_sum;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    logic      rsp_valid_reg, rsp_valid_next;
    out_item_t rsp_reg, rsp_next;

    ivw_seq #(
        .MAX_INTERVALS(MAX_INTERVALS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd      (cmd),
        .cmd_stall(cmd_stall),
        .rsp_free (rsp_free),
        .res_load (res_load),
        .res      (res),
        .alu_op   (alu_op),
        .alu_a    (alu_a),
        .alu_b    (alu_b),
        .alu_sum  (alu_sum),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    ivw_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .sum(alu_sum)
    );

    ivw_store #(
        .DEPTH(MAX_INTERVALS)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Output slot is free when empty or being taken this cycle
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // Load a finished result, drop a taken one
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted item keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("block took a second item right after the first");

    // A finished result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result loaded over a waiting result");

    // A loaded result shows up at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> rsp_valid)
        else $error("loaded result missing at output");

    // While ready for an item, no result is pending in the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_stall |-> !res_load)
        else $error("result pending while ready for an item");

endmodule

// ----- design/ivw_store.sv -----
// ----------------------------------------------------------------------------
// ivw_store: interval table memory
// One write port and one read port with registered read data; each row holds
// an interval's start, length and end.
// ----------------------------------------------------------------------------
module ivw_store #(
    parameter int  DEPTH = 256,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  ivw_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output ivw_pkg::entry_t rd_data
);
    import ivw_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write a new row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read a row, hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/ivw_alu.sv -----
// ----------------------------------------------------------------------------
// ivw_alu: shared adder
// One carry-out adder with operand and carry-in selection; the carry-out
// bit serves as borrow for subtraction and as overflow for addition.
// ----------------------------------------------------------------------------
module ivw_alu (
    input  ivw_pkg::alu_op_t op,
    input  ivw_pkg::value_t  a,
    input  ivw_pkg::value_t  b,
    output ivw_pkg::sum_t    sum
);
    import ivw_pkg::*;

    sum_t ext_a;
    sum_t ext_b;
    sum_t opb;
    logic cin;

    assign ext_a = {1'b0, a};
    assign ext_b = {1'b0, b};

    // Select second operand and carry-in
    always_comb
    begin
        opb = '0;
        cin = 1'b0;
        case (op)
            ALU_DEC:
            begin
                opb = '1;
                cin = 1'b0;
            end
            ALU_SUB:
            begin
                opb = ~ext_b;
                cin = 1'b1;
            end
            ALU_INC:
            begin
                opb = '0;
                cin = 1'b1;
            end
            ALU_ADD:
            begin
                opb = ext_b;
                cin = 1'b0;
            end
            ALU_ADD_INC:
            begin
                opb = ext_b;
                cin = 1'b1;
            end
            default:
            begin
                opb = '0;
                cin = 1'b0;
            end
        endcase
    end

    assign sum = ext_a + opb + SUM_W'(cin);

endmodule

// ----- design/ivw_seq.sv -----
// ----------------------------------------------------------------------------
// ivw_seq: item sequencer
// Decodes each item, drives the shared adder and the table ports step by
// step, keeps the entry count and builds the pending result.
// ----------------------------------------------------------------------------
module ivw_seq #(
    parameter int  MAX_INTERVALS = 256,
    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  ivw_pkg::in_item_t  cmd,
    output logic               cmd_stall,
    input  logic               rsp_free,
    output logic               res_load,
    output ivw_pkg::out_item_t res,
    output ivw_pkg::alu_op_t   alu_op,
    output ivw_pkg::value_t    alu_a,
    output ivw_pkg::value_t    alu_b,
    input  ivw_pkg::sum_t      alu_sum,
    output logic               wr_en,
    output logic [IDX_W-1:0]   wr_addr,
    output ivw_pkg::entry_t    wr_data,
    output logic               rd_en,
    output logic [IDX_W-1:0]   rd_addr,
    input  ivw_pkg::entry_t    rd_data
);
    import ivw_pkg::*;

    state_t     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    value_t     rem_reg, rem_next;
    value_t     lo_reg, lo_next;
    value_t     hi_reg, hi_next;
    logic       neg_reg, neg_next;
    logic       sel_end_reg, sel_end_next;
    out_item_t  res_reg, res_next;

    logic             full;
    logic             sum_neg;
    value_t           sum_low;
    logic [CNT_W-1:0] idx_inc;
    logic             last;
    logic             walk_more;
    logic             read_req;

    assign full    = (count_reg == CNT_W'(MAX_INTERVALS));
    assign sum_neg = alu_sum[VALUE_BITS];
    assign sum_low = alu_sum[VALUE_BITS-1:0];
    assign idx_inc = CNT_W'(idx_reg) + CNT_W'(1);
    assign last    = (idx_inc == count_reg);
    assign walk_more = !sum_neg && !last;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_APPEND:
                        begin
                            state_next = full ? S_DONE : S_APP_DIFF;
                        end
                        OP_QUERY:
                        begin
                            if ((count_reg == '0) || (cmd.rank == '0))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_Q_INIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_APP_DIFF:
            begin
                state_next = S_APP_LEN;
            end
            S_APP_LEN:
            begin
                state_next = S_DONE;
            end
            S_Q_INIT:
            begin
                state_next = S_Q_WALK;
            end
            S_Q_WALK:
            begin
                if (!walk_more)
                begin
                    state_next = S_Q_FIN;
                end
            end
            S_Q_FIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Adder operands, table ports and handshake
    always_comb
    begin
        alu_op   = ALU_ADD;
        alu_a    = rem_reg;
        alu_b    = rd_data.start_value;
        wr_en    = 1'b0;
        read_req = 1'b0;
        rd_addr  = idx_inc[IDX_W-1:0];
        case (state_reg)
            S_APP_DIFF:
            begin
                alu_op = ALU_SUB;
                alu_a  = hi_reg;
                alu_b  = lo_reg;
            end
            S_APP_LEN:
            begin
                alu_op = ALU_INC;
                wr_en  = 1'b1;
            end
            S_Q_INIT:
            begin
                alu_op   = ALU_DEC;
                read_req = 1'b1;
                rd_addr  = '0;
            end
            S_Q_WALK:
            begin
                alu_op = ALU_SUB;
                alu_b  = rd_data.length;
            end
            S_Q_FIN:
            begin
                alu_op = sel_end_reg ? ALU_ADD_INC : ALU_ADD;
                alu_b  = sel_end_reg ? rd_data.end_value : rd_data.start_value;
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // Fetch the first row when a query starts, the next row only while the walk goes on
    assign rd_en     = read_req || ((state_reg == S_Q_WALK) && walk_more);
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_load  = (state_reg == S_DONE) && rsp_free;
    assign res       = res_reg;

    // New row: inverted interval gets length zero, oversized one saturates
    assign wr_addr               = count_reg[IDX_W-1:0];
    assign wr_data.start_value   = lo_reg;
    assign wr_data.end_value     = hi_reg;
    assign wr_data.length        = neg_reg ? '0 : (sum_neg ? VALUE_MAX : sum_low);

    // Datapath next values
    always_comb
    begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        rem_next     = rem_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        neg_next     = neg_reg;
        sel_end_next = sel_end_reg;
        res_next     = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    lo_next  = cmd.interval_low;
                    hi_next  = cmd.interval_high;
                    rem_next = cmd.rank;
                    res_next = '{value: '0, status: ST_OK};
                    case (cmd.op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                res_next.status = ST_FULL;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else if (cmd.rank == '0)
                            begin
                                res_next.status = ST_RANK_ZERO;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end
            S_APP_DIFF:
            begin
                rem_next = sum_low;
                neg_next = sum_neg;
            end
            S_APP_LEN:
            begin
                count_next = count_reg + CNT_W'(1);
            end
            S_Q_INIT:
            begin
                rem_next = sum_low;
                idx_next = '0;
            end
            S_Q_WALK:
            begin
                // Subtract the row length unless the rank falls inside it
                sel_end_next = !sum_neg;
                if (!sum_neg)
                begin
                    rem_next = sum_low;
                end
                if (walk_more)
                begin
                    idx_next = idx_inc[IDX_W-1:0];
                end
            end
            S_Q_FIN:
            begin
                res_next.value  = sum_neg ? VALUE_MAX : sum_low;
                res_next.status = sum_neg ? ST_SATURATED : ST_OK;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        neg_reg     <= neg_next;
        sel_end_reg <= sel_end_next;
        res_reg     <= res_next;
    end

endmodule
